### sv/rsh_pkg.sv
`default_nettype none

package rsh_pkg;

	// Coordinate format: signed fixed point, CW bits with FW fraction bits
	localparam int CW = 32;
	localparam int FW = 16;
	localparam int RW = CW - 1;          // radius register width
	localparam int RRW = 2 * RW;         // radius squared width
	localparam int MW = 2 * CW;          // magnitude of A, b and C
	localparam int BW = MW + 1;          // signed b and C
	localparam int PW = 2 * MW;          // b*b and A*|C|
	localparam int DW = PW + 2;          // signed discriminant
	localparam int DMW = 4 * CW - 2;     // bits of a non-negative discriminant (D <= A*r*r)
	localparam int QW = (DMW + 2 * FW) / 2; // square root width
	localparam int RDW = 2 * QW;         // radicand width
	localparam int RMW = QW + 2;         // square root partial remainder
	localparam int NW = MW + FW + 2;     // signed numerator and root
	localparam int GW = NW - 1;          // numerator magnitude, quotient steps

	// Result reason codes
	localparam logic [1:0] OUT_HIT     = 2'd0;
	localparam logic [1:0] OUT_NOROOT  = 2'd1;
	localparam logic [1:0] OUT_RANGE   = 2'd2;
	localparam logic [1:0] OUT_ZERODIR = 2'd3;

	typedef struct packed {
		logic signed [CW-1:0] tn;
		logic signed [CW-1:0] tf;
	} win_t;

	// Data that rides along the square root pipeline
	typedef struct packed {
		logic signed [BW-1:0] b;
		logic [MW-1:0]        a;
		logic [1:0]           code;
		win_t                 win;
	} sq_side_t;

	// Data that rides along the divider pipeline
	typedef struct packed {
		logic [MW-1:0] a;
		logic          neg0;
		logic          neg1;
		logic [1:0]    code;
		win_t          win;
	} dv_side_t;

	// Both floored roots and what the selector needs
	typedef struct packed {
		logic signed [NW-1:0] t0;
		logic signed [NW-1:0] t1;
		logic [1:0]           code;
		win_t                 win;
	} roots_t;

	typedef struct packed {
		logic [1:0]           outcome;
		logic signed [CW-1:0] t_hit;
		logic                 hit;
	} res_t;

endpackage

`default_nettype wire

### sv/ray_sphere_hit_test.sv
// Ray against origin-centred sphere hit test. Each input beat is one ray in
// object space (origin, direction, accepted interval, signed Q16.16); each
// output beat gives the hit flag, the nearest root inside the interval
// (saturated, zero on a miss) and a reason code. One ray is accepted every
// cycle while the skid entry is empty, and results come back in order after
// the 79-stage square root and the two 81-stage dividers that run side by
// side. The radius register may only be written while no ray is in flight.
`default_nettype none

module ray_sphere_hit_test (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    s_tvalid,
	output logic                         s_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_near, t_far
	input  wire logic [255:0]            s_tdata,
	output logic                         m_tvalid,
	input  wire logic                    m_tready,
	// hit, t_hit, outcome, zero fill
	output logic [39:0]                  m_tdata,
	input  wire logic                    radius_we,
	input  wire logic [rsh_pkg::RW-1:0]  radius_wdata
);

	localparam int CW = rsh_pkg::CW;

	logic [rsh_pkg::RW-1:0] radius_q;

	logic                    adv;
	logic                    f_valid;
	logic [rsh_pkg::RDW-1:0] f_rad;
	rsh_pkg::sq_side_t       f_side;
	logic                    q_valid;
	logic [rsh_pkg::QW-1:0]  q_root;
	rsh_pkg::sq_side_t       q_side;
	logic                    d_valid;
	rsh_pkg::roots_t         d_roots;
	logic                    p_valid;
	rsh_pkg::res_t           p_res;

	logic                    out_v_q, skid_v_q;
	rsh_pkg::res_t           out_q, skid_q;
	logic                    take;

	// Radius register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= rsh_pkg::RW'(65536);
		end else if (radius_we) begin
			radius_q <= radius_wdata;
		end
	end

	// The whole pipeline holds while the skid stage is occupied
	assign adv      = !skid_v_q;
	assign s_tready = adv;

	rsh_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (s_tvalid),
		.origin_x  (s_tdata[0*CW +: CW]),
		.origin_y  (s_tdata[1*CW +: CW]),
		.origin_z  (s_tdata[2*CW +: CW]),
		.dir_x     (s_tdata[3*CW +: CW]),
		.dir_y     (s_tdata[4*CW +: CW]),
		.dir_z     (s_tdata[5*CW +: CW]),
		.t_near    (s_tdata[6*CW +: CW]),
		.t_far     (s_tdata[7*CW +: CW]),
		.radius_q  (radius_q),
		.out_valid (f_valid),
		.out_rad   (f_rad),
		.out_side  (f_side)
	);

	rsh_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (f_valid),
		.in_rad    (f_rad),
		.in_side   (f_side),
		.out_valid (q_valid),
		.out_root  (q_root),
		.out_side  (q_side)
	);

	rsh_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (q_valid),
		.in_root   (q_root),
		.in_side   (q_side),
		.out_valid (d_valid),
		.out_roots (d_roots)
	);

	rsh_pick u_pick (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (d_valid),
		.in_roots  (d_roots),
		.out_valid (p_valid),
		.out_res   (p_res)
	);

	// Output register with a skid entry behind it
	assign take = out_v_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take) begin
				skid_v_q <= 1'b0;
			end
		end else if (p_valid) begin
			if (out_v_q && !take) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end else if (take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (p_valid) begin
			if (out_v_q && !take) begin
				skid_q <= p_res;
			end else begin
				out_q <= p_res;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {5'b0, out_q.outcome, out_q.t_hit, out_q.hit};

endmodule

`default_nettype wire

### sv/rsh_front.sv
`default_nettype none

module rsh_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         adv,
	input  wire logic                         in_valid,
	input  wire logic signed [rsh_pkg::CW-1:0] origin_x,
	input  wire logic signed [rsh_pkg::CW-1:0] origin_y,
	input  wire logic signed [rsh_pkg::CW-1:0] origin_z,
	input  wire logic signed [rsh_pkg::CW-1:0] dir_x,
	input  wire logic signed [rsh_pkg::CW-1:0] dir_y,
	input  wire logic signed [rsh_pkg::CW-1:0] dir_z,
	input  wire logic signed [rsh_pkg::CW-1:0] t_near,
	input  wire logic signed [rsh_pkg::CW-1:0] t_far,
	input  wire logic [rsh_pkg::RW-1:0]        radius_q,
	output logic                               out_valid,
	output logic [rsh_pkg::RDW-1:0]            out_rad,
	output rsh_pkg::sq_side_t                  out_side
);

	localparam int CW = rsh_pkg::CW;
	localparam int MW = rsh_pkg::MW;
	localparam int BW = rsh_pkg::BW;
	localparam int PW = rsh_pkg::PW;
	localparam int DW = rsh_pkg::DW;
	localparam int DMW = rsh_pkg::DMW;
	localparam int FW = rsh_pkg::FW;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic signed [MW-1:0] dd_s1 [3];
	logic signed [MW-1:0] od_s1 [3];
	logic signed [MW-1:0] oo_s1 [3];
	logic [rsh_pkg::RRW-1:0] rr_s1;
	rsh_pkg::win_t win_s1, win_s2, win_s3, win_s4, win_s5, win_s6;

	logic [MW-1:0]        a_s2;
	logic signed [BW-1:0] b_s2;
	logic signed [BW-1:0] c_s2;

	logic [MW-1:0]        a_s3, a_s4, a_s5, a_s6;
	logic signed [BW-1:0] b_s3, b_s4, b_s5, b_s6;
	logic [MW-1:0]        bm_s3;
	logic [MW-1:0]        cm_s3;
	logic                 cn_s3, cn_s4, cn_s5;
	logic [1:0]           code_s3, code_s4, code_s5, code_s6;

	logic [MW-1:0] bll_s4, blh_s4, bhh_s4;
	logic [MW-1:0] all_s4, alh_s4, ahl_s4, ahh_s4;

	logic [PW-1:0] bb_s5, ac_s5;

	logic [rsh_pkg::RDW-1:0] rad_s6;
	logic signed [DW-1:0]    d_c;

	// Valid bits move only when the pipeline advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Stage 1: component products and radius squared
	always_ff @(posedge clk) begin
		if (adv) begin
			dd_s1[0] <= dir_x * dir_x;
			dd_s1[1] <= dir_y * dir_y;
			dd_s1[2] <= dir_z * dir_z;
			od_s1[0] <= origin_x * dir_x;
			od_s1[1] <= origin_y * dir_y;
			od_s1[2] <= origin_z * dir_z;
			oo_s1[0] <= origin_x * origin_x;
			oo_s1[1] <= origin_y * origin_y;
			oo_s1[2] <= origin_z * origin_z;
			rr_s1    <= radius_q * radius_q;
			win_s1   <= '{tn: t_near, tf: t_far};
		end
	end

	// Stage 2: quadratic coefficients A, b, C
	always_ff @(posedge clk) begin
		if (adv) begin
			a_s2   <= dd_s1[0] + dd_s1[1] + dd_s1[2];
			b_s2   <= BW'(od_s1[0]) + BW'(od_s1[1]) + BW'(od_s1[2]);
			c_s2   <= BW'(oo_s1[0]) + BW'(oo_s1[1]) + BW'(oo_s1[2]) - $signed(BW'(rr_s1));
			win_s2 <= win_s1;
		end
	end

	// Stage 3: magnitudes for the unsigned multiplies, flag a zero direction
	always_ff @(posedge clk) begin
		if (adv) begin
			a_s3    <= a_s2;
			b_s3    <= b_s2;
			bm_s3   <= MW'(b_s2[BW-1] ? -b_s2 : b_s2);
			cm_s3   <= MW'(c_s2[BW-1] ? -c_s2 : c_s2);
			cn_s3   <= c_s2[BW-1];
			code_s3 <= (a_s2 == '0) ? rsh_pkg::OUT_ZERODIR : rsh_pkg::OUT_HIT;
			win_s3  <= win_s2;
		end
	end

	// Stage 4: 32x32 partial products of b*b and A*|C|
	always_ff @(posedge clk) begin
		if (adv) begin
			bll_s4  <= bm_s3[CW-1:0] * bm_s3[CW-1:0];
			blh_s4  <= bm_s3[CW-1:0] * bm_s3[MW-1:CW];
			bhh_s4  <= bm_s3[MW-1:CW] * bm_s3[MW-1:CW];
			all_s4  <= a_s3[CW-1:0] * cm_s3[CW-1:0];
			alh_s4  <= a_s3[CW-1:0] * cm_s3[MW-1:CW];
			ahl_s4  <= a_s3[MW-1:CW] * cm_s3[CW-1:0];
			ahh_s4  <= a_s3[MW-1:CW] * cm_s3[MW-1:CW];
			a_s4    <= a_s3;
			b_s4    <= b_s3;
			cn_s4   <= cn_s3;
			code_s4 <= code_s3;
			win_s4  <= win_s3;
		end
	end

	// Stage 5: assemble the two wide products
	always_ff @(posedge clk) begin
		if (adv) begin
			bb_s5   <= {bhh_s4, bll_s4} + (PW'(blh_s4) << (CW + 1));
			ac_s5   <= {ahh_s4, all_s4} + (PW'(alh_s4) << CW) + (PW'(ahl_s4) << CW);
			a_s5    <= a_s4;
			b_s5    <= b_s4;
			cn_s5   <= cn_s4;
			code_s5 <= code_s4;
			win_s5  <= win_s4;
		end
	end

	// Stage 6: discriminant, reject a negative one, form the radicand D*S*S
	assign d_c = cn_s5 ? $signed(DW'(bb_s5) + DW'(ac_s5)) : $signed(DW'(bb_s5) - DW'(ac_s5));

	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s6 <= d_c[DW-1] ? '0 : {d_c[DMW-1:0], (2 * FW)'(0)};
			if (code_s5 == rsh_pkg::OUT_HIT && d_c[DW-1]) begin
				code_s6 <= rsh_pkg::OUT_NOROOT;
			end else begin
				code_s6 <= code_s5;
			end
			a_s6   <= a_s5;
			b_s6   <= b_s5;
			win_s6 <= win_s5;
		end
	end

	assign out_valid = v_s6;
	assign out_rad   = rad_s6;
	assign out_side  = '{b: b_s6, a: a_s6, code: code_s6, win: win_s6};

endmodule

`default_nettype wire

### sv/rsh_sqrt.sv
`default_nettype none

module rsh_sqrt (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    adv,
	input  wire logic                    in_valid,
	input  wire logic [rsh_pkg::RDW-1:0] in_rad,
	input  wire rsh_pkg::sq_side_t       in_side,
	output logic                         out_valid,
	output logic [rsh_pkg::QW-1:0]       out_root,
	output rsh_pkg::sq_side_t            out_side
);

	localparam int QW = rsh_pkg::QW;
	localparam int RDW = rsh_pkg::RDW;
	localparam int RMW = rsh_pkg::RMW;

	logic [RMW-1:0]    rem_s  [QW];
	logic [QW-1:0]     root_s [QW];
	logic [RDW-1:0]    rad_s  [QW];
	rsh_pkg::sq_side_t side_s [QW];
	logic              v_s    [QW];

	// One result bit per stage, most significant first
	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [RMW-1:0]    rem_p;
		logic [QW-1:0]     root_p;
		logic [RDW-1:0]    rad_p;
		rsh_pkg::sq_side_t side_p;
		logic              v_p;
		logic [RMW-1:0]    sh;
		logic [RMW-1:0]    trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign rem_p  = '0;
			assign root_p = '0;
			assign rad_p  = in_rad;
			assign side_p = in_side;
			assign v_p    = in_valid;
		end else begin : g_next
			assign rem_p  = rem_s[k-1];
			assign root_p = root_s[k-1];
			assign rad_p  = rad_s[k-1];
			assign side_p = side_s[k-1];
			assign v_p    = v_s[k-1];
		end

		// Bring down two radicand bits and try root*4+1
		assign sh    = {rem_p[RMW-3:0], rad_p[RDW-1 -: 2]};
		assign trial = {root_p, 2'b01};
		assign ge    = (sh >= trial);

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k]  <= ge ? (sh - trial) : sh;
				root_s[k] <= {root_p[QW-2:0], ge};
				rad_s[k]  <= rad_p << 2;
				side_s[k] <= side_p;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (adv) begin
				v_s[k] <= v_p;
			end
		end
	end

	assign out_valid = v_s[QW-1];
	assign out_root  = root_s[QW-1];
	assign out_side  = side_s[QW-1];

endmodule

`default_nettype wire

### sv/rsh_div.sv
`default_nettype none

module rsh_div (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  adv,
	input  wire logic                  in_valid,
	input  wire logic [rsh_pkg::QW-1:0] in_root,
	input  wire rsh_pkg::sq_side_t     in_side,
	output logic                       out_valid,
	output rsh_pkg::roots_t            out_roots
);

	localparam int NW = rsh_pkg::NW;
	localparam int GW = rsh_pkg::GW;
	localparam int MW = rsh_pkg::MW;
	localparam int FW = rsh_pkg::FW;

	logic signed [NW-1:0] bs_c;

	logic                 v_s1, v_s2, v_sf;
	logic signed [NW-1:0] p0_s1, n1_s1;
	logic [MW-1:0]        a_s1;
	logic [1:0]           code_s1;
	rsh_pkg::win_t        win_s1;

	logic [GW-1:0]        m0_s2, m1_s2;
	rsh_pkg::dv_side_t    side_s2;

	logic [MW-1:0]        rem_s  [2][GW];
	logic [GW-1:0]        quo_s  [2][GW];
	rsh_pkg::dv_side_t    side_s [GW];
	logic                 v_s    [GW];

	rsh_pkg::roots_t      roots_sf;

	// Numerators: -b*S - q is the negation of p0 = b*S + q, and q - b*S
	assign bs_c = NW'(in_side.b) <<< FW;

	always_ff @(posedge clk) begin
		if (adv) begin
			p0_s1   <= bs_c + $signed(NW'(in_root));
			n1_s1   <= $signed(NW'(in_root)) - bs_c;
			a_s1    <= in_side.a;
			code_s1 <= in_side.code;
			win_s1  <= in_side.win;
		end
	end

	// Split into sign and magnitude
	always_ff @(posedge clk) begin
		if (adv) begin
			m0_s2   <= GW'(p0_s1[NW-1] ? -p0_s1 : p0_s1);
			m1_s2   <= GW'(n1_s1[NW-1] ? -n1_s1 : n1_s1);
			side_s2 <= '{a: a_s1, neg0: (!p0_s1[NW-1] && p0_s1 != '0), neg1: n1_s1[NW-1],
				code: code_s1, win: win_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_sf <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_sf <= v_s[GW-1];
		end
	end

	// Restoring division, one quotient bit per stage for both roots
	for (genvar k = 0; k < GW; k++) begin : g_step
		rsh_pkg::dv_side_t side_p;
		logic              v_p;

		if (k == 0) begin : g_first
			assign side_p = side_s2;
			assign v_p    = v_s2;
		end else begin : g_next
			assign side_p = side_s[k-1];
			assign v_p    = v_s[k-1];
		end

		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic [MW-1:0] rem_p;
			logic [GW-1:0] quo_p;
			logic [MW:0]   sh;
			logic          ge;

			if (k == 0) begin : g_first
				assign rem_p = '0;
				assign quo_p = (l == 0) ? m0_s2 : m1_s2;
			end else begin : g_next
				assign rem_p = rem_s[l][k-1];
				assign quo_p = quo_s[l][k-1];
			end

			// Dividend bits leave the top, quotient bits enter the bottom
			assign sh = {rem_p, quo_p[GW-1]};
			assign ge = (sh >= {1'b0, side_p.a});

			always_ff @(posedge clk) begin
				if (adv) begin
					rem_s[l][k] <= ge ? MW'(sh - {1'b0, side_p.a}) : MW'(sh);
					quo_s[l][k] <= {quo_p[GW-2:0], ge};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				side_s[k] <= side_p;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (adv) begin
				v_s[k] <= v_p;
			end
		end
	end

	// Round negative quotients toward minus infinity
	function automatic logic signed [NW-1:0] floor_q(input logic [GW-1:0] quo,
		input logic [MW-1:0] rem, input logic neg);
		logic signed [NW-1:0] qx;
		qx = $signed({1'b0, quo});
		if (!neg) begin
			return qx;
		end else if (rem != '0) begin
			return ~qx;
		end else begin
			return -qx;
		end
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			roots_sf <= '{
				t0: floor_q(quo_s[0][GW-1], rem_s[0][GW-1], side_s[GW-1].neg0),
				t1: floor_q(quo_s[1][GW-1], rem_s[1][GW-1], side_s[GW-1].neg1),
				code: side_s[GW-1].code,
				win: side_s[GW-1].win};
		end
	end

	assign out_valid = v_sf;
	assign out_roots = roots_sf;

endmodule

`default_nettype wire

### sv/rsh_pick.sv
`default_nettype none

module rsh_pick (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            adv,
	input  wire logic            in_valid,
	input  wire rsh_pkg::roots_t in_roots,
	output logic                 out_valid,
	output rsh_pkg::res_t        out_res
);

	localparam int NW = rsh_pkg::NW;
	localparam int CW = rsh_pkg::CW;

	logic signed [NW-1:0] tn_c, tf_c;

	logic                 v_s1, v_s2;
	logic                 g0f_s1, l1n_s1, l0n_s1, g1f_s1;
	logic signed [CW-1:0] sat0_s1, sat1_s1;
	logic [1:0]           code_s1;
	rsh_pkg::res_t        res_s2;

	// Clamp a root to the output range
	function automatic logic signed [CW-1:0] sat(input logic signed [NW-1:0] t);
		logic [NW-CW:0] top;
		top = t[NW-1:CW-1];
		if (&top || ~|top) begin
			return t[CW-1:0];
		end else if (t[NW-1]) begin
			return {1'b1, {(CW-1){1'b0}}};
		end else begin
			return {1'b0, {(CW-1){1'b1}}};
		end
	endfunction

	assign tn_c = NW'(in_roots.win.tn);
	assign tf_c = NW'(in_roots.win.tf);

	// Stage 1: interval compares on the full roots, clamp both candidates
	always_ff @(posedge clk) begin
		if (adv) begin
			g0f_s1  <= in_roots.t0 > tf_c;
			l1n_s1  <= in_roots.t1 < tn_c;
			l0n_s1  <= in_roots.t0 < tn_c;
			g1f_s1  <= in_roots.t1 > tf_c;
			sat0_s1 <= sat(in_roots.t0);
			sat1_s1 <= sat(in_roots.t1);
			code_s1 <= in_roots.code;
		end
	end

	// Stage 2: choose the nearer root in the interval, or give the miss reason
	always_ff @(posedge clk) begin
		if (adv) begin
			if (code_s1 != rsh_pkg::OUT_HIT) begin
				res_s2 <= '{outcome: code_s1, t_hit: '0, hit: 1'b0};
			end else if (!(g0f_s1 || l1n_s1) && !l0n_s1) begin
				res_s2 <= '{outcome: rsh_pkg::OUT_HIT, t_hit: sat0_s1, hit: 1'b1};
			end else if (!(g0f_s1 || l1n_s1) && !g1f_s1) begin
				res_s2 <= '{outcome: rsh_pkg::OUT_HIT, t_hit: sat1_s1, hit: 1'b1};
			end else begin
				res_s2 <= '{outcome: rsh_pkg::OUT_RANGE, t_hit: '0, hit: 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	assign out_valid = v_s2;
	assign out_res   = res_s2;

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none

module tb_top;

	localparam int Q1 = 65536;
	localparam int LATENCY_WAIT = 220;

	typedef struct packed {
		logic [1:0]                    outcome;
		logic signed [rsh_pkg::CW-1:0] t_hit;
		logic                          hit;
	} hit_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [255:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic radius_we = 1'b0;
	logic [rsh_pkg::RW-1:0] radius_wdata = '0;

	ray_sphere_hit_test dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.radius_we(radius_we),
		.radius_wdata(radius_wdata)
	);

	always #10 clk = ~clk;

	logic [255:0] ray_queue[$];
	hit_beat_t hit_queue[$];
	logic [rsh_pkg::RW-1:0] sphere_radius = rsh_pkg::RW'(Q1);
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit send_hold = 1'b0;
	bit long_stall_req = 1'b0;
	int stall_left = 0;
	int mismatches = 0;

	// floor(n / a) for a > 0
	function automatic logic signed [255:0] floor_div(logic signed [255:0] n,
			logic signed [255:0] a);
		logic signed [255:0] quo;
		quo = n / a;
		if ((n % a) != 0 && n < 0)
			quo = quo - 1;
		return quo;
	endfunction

	// Solve |o + t*d|^2 = r^2 exactly and pick the nearest root in the window
	function automatic hit_beat_t sphere_hit(logic [255:0] ray,
			logic [rsh_pkg::RW-1:0] rad);
		logic signed [255:0] o[3];
		logic signed [255:0] d[3];
		logic signed [255:0] tn, tf, a, b, c, disc, radicand, root, cand, t0, t1, th, r;
		hit_beat_t res;
		for (int i = 0; i < 3; i++) begin
			o[i] = $signed(ray[32*i +: 32]);
			d[i] = $signed(ray[32*(i+3) +: 32]);
		end
		tn = $signed(ray[223:192]);
		tf = $signed(ray[255:224]);
		res = '0;
		a = 0; b = 0; c = 0;
		for (int i = 0; i < 3; i++) begin
			a = a + d[i] * d[i];
			b = b + o[i] * d[i];
			c = c + o[i] * o[i];
		end
		if (a == 0) begin
			res.outcome = rsh_pkg::OUT_ZERODIR;
			return res;
		end
		r = $signed({1'b0, rad});
		c = c - r * r;
		disc = b * b - a * c;
		if (disc < 0) begin
			res.outcome = rsh_pkg::OUT_NOROOT;
			return res;
		end
		radicand = disc <<< (2 * rsh_pkg::FW);
		root = 0;
		for (int i = 95; i >= 0; i--) begin
			cand = root | (256'sd1 <<< i);
			if (cand * cand <= radicand)
				root = cand;
		end
		t0 = floor_div(-(b <<< rsh_pkg::FW) - root, a);
		t1 = floor_div(-(b <<< rsh_pkg::FW) + root, a);
		res.outcome = rsh_pkg::OUT_RANGE;
		if (t0 > tf || t1 < tn)
			return res;
		th = t0;
		if (t0 < tn) begin
			th = t1;
			if (th > tf)
				return res;
		end
		res.hit = 1'b1;
		res.outcome = rsh_pkg::OUT_HIT;
		if (th > 256'sd2147483647)
			res.t_hit = 32'h7fffffff;
		else if (th < -256'sd2147483648)
			res.t_hit = 32'h80000000;
		else
			res.t_hit = th[31:0];
		return res;
	endfunction

	function automatic logic [255:0] pack_ray(int ox, int oy, int oz, int dx, int dy,
			int dz, int tn, int tf);
		return {tf, tn, dz, dy, dx, oz, oy, ox};
	endfunction

	function automatic int small_val(int span);
		return $signed($urandom_range(2 * span)) - span;
	endfunction

	// Mostly rays near the unit scale so that hits and grazes are common
	function automatic logic [255:0] random_ray();
		int tn;
		if ($urandom_range(99) < 25)
			return {$urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom};
		tn = small_val(4 * Q1);
		return pack_ray(small_val(4 * Q1), small_val(4 * Q1), small_val(4 * Q1),
			small_val(2 * Q1), small_val(2 * Q1), small_val(2 * Q1),
			tn, $urandom_range(99) < 90 ? tn + $urandom_range(8 * Q1) : small_val(4 * Q1));
	endfunction

	// Drive ray beats; predict at acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				hit_queue.push_back(sphere_hit(s_tdata, sphere_radius));
			if (!s_tvalid || s_tready) begin
				if (ray_queue.size() > 0 && !send_hold
						&& $urandom_range(99) >= send_idle_pct) begin
					s_tdata <= ray_queue.pop_front();
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Check result beats and throttle the output
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (hit_queue.size() == 0) begin
					$display("%0t: unexpected beat, actual %h", $time, m_tdata);
					mismatches++;
				end else begin
					hit_beat_t want;
					want = hit_queue.pop_front();
					if (m_tdata[0] !== want.hit || m_tdata[32:1] !== want.t_hit
							|| m_tdata[34:33] !== want.outcome) begin
						$display("%0t: mismatch expected hit=%0d t=%h oc=%0d actual hit=%0d t=%h oc=%0d",
							$time, want.hit, want.t_hit, want.outcome,
							m_tdata[0], m_tdata[32:1], m_tdata[34:33]);
						mismatches++;
					end
				end
			end
			if (long_stall_req && stall_left == 0) begin
				long_stall_req = 1'b0;
				stall_left = 400;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic wait_drained();
		while (ray_queue.size() != 0 || s_tvalid || hit_queue.size() != 0)
			@(posedge clk);
		repeat (LATENCY_WAIT) @(posedge clk);
	endtask

	task automatic write_radius(logic [rsh_pkg::RW-1:0] value);
		@(posedge clk);
		radius_we <= 1'b1;
		radius_wdata <= value;
		sphere_radius = value;
		@(posedge clk);
		radius_we <= 1'b0;
	endtask

	initial begin
		logic [rsh_pkg::RW-1:0] radii[5];
		radii = '{rsh_pkg::RW'(Q1), rsh_pkg::RW'(1), {rsh_pkg::RW{1'b1}},
			rsh_pkg::RW'(3 * Q1 / 2), rsh_pkg::RW'(Q1 / 2)};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed rays at the reset radius of one unit
		ray_queue.push_back(pack_ray(Q1, 0, 0, 0, 0, 0, 0, Q1));                 // zero dir
		ray_queue.push_back(pack_ray(-3 * Q1, 2 * Q1, 0, Q1, 0, 0, 0, 8 * Q1));  // no root
		ray_queue.push_back(pack_ray(-2 * Q1, Q1, 0, Q1, 0, 0, 0, 8 * Q1));      // tangent
		ray_queue.push_back(pack_ray(-3 * Q1, 0, 0, Q1, 0, 0, 0, 8 * Q1));       // front hit
		ray_queue.push_back(pack_ray(0, 0, 0, 0, Q1, 0, 0, 8 * Q1));             // from inside
		ray_queue.push_back(pack_ray(-3 * Q1, 0, 0, Q1, 0, 0, 3 * Q1, 8 * Q1));  // far root
		ray_queue.push_back(pack_ray(-3 * Q1, 0, 0, Q1, 0, 0, 0, Q1));           // short window
		ray_queue.push_back(pack_ray(-3 * Q1, 0, 0, Q1, 0, 0, 5 * Q1, 6 * Q1));  // past sphere
		ray_queue.push_back(pack_ray(-3 * Q1, 0, 0, Q1, 0, 0, 8 * Q1, 0));       // reversed
		ray_queue.push_back(pack_ray(-100 * Q1, 0, 0, 1, 0, 0,
			32'h80000000, 32'h7fffffff));                                         // roots above window
		ray_queue.push_back(pack_ray(100 * Q1, 0, 0, 1, 0, 0,
			32'h80000000, 32'h7fffffff));                                         // roots below window
		ray_queue.push_back(pack_ray(0, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h80000000, 32'h7fffffff));
		ray_queue.push_back(pack_ray(32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff));
		ray_queue.push_back({8{32'hffffffff}});
		ray_queue.push_back({8{32'h7fffffff}});
		ray_queue.push_back({8{32'h80000000}});
		wait_drained();

		for (int ph = 0; ph < 5; ph++) begin
			write_radius(radii[ph]);
			send_idle_pct = (ph < 2) ? 13 : (ph < 4) ? 87 : 0;
			recv_idle_pct = (ph < 2) ? 87 : (ph < 4) ? 13 : 0;
			if (ph == 4)
				long_stall_req = 1'b1;
			for (int i = 0; i < 307; i++)
				ray_queue.push_back(random_ray());
			if (ph == 2) begin
				// Hold the sender until the pipe is empty mid-phase
				while (ray_queue.size() > 150)
					@(posedge clk);
				send_hold = 1'b1;
				while (hit_queue.size() != 0 || s_tvalid)
					@(posedge clk);
				send_hold = 1'b0;
			end
			wait_drained();
		end

		if (mismatches == 0 && hit_queue.size() == 0)
			$display("[ray_sphere_hit_test] OK");
		else
			$display("[ray_sphere_hit_test] ERROR");
		$finish;
	end

	initial begin
		#40000000;
		$display("[ray_sphere_hit_test] ERROR");
		$finish;
	end

endmodule

`default_nettype wire

### files.f
sv/rsh_pkg.sv
sv/rsh_front.sv
sv/rsh_sqrt.sv
sv/rsh_div.sv
sv/rsh_pick.sv
sv/ray_sphere_hit_test.sv
test/tb_top.sv
